// ===== hw/rtl/array_extremes_and_duplicates_unit_assert.svh =====
// Assertion macros for the array extremes and duplicates unit.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef ARRAY_EXTREMES_AND_DUPLICATES_UNIT_ASSERT_SVH
`define ARRAY_EXTREMES_AND_DUPLICATES_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define AEDU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aedu: property failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define AEDU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aedu: property failed");

`endif

// ===== hw/rtl/aedu_pkg.sv =====
// Shared types and constants of the array extremes and duplicates unit.
// No dependencies; every other RTL file except aedu_ram refers to it by scoped names.
package aedu_pkg;

    // Store size and derived widths.
    localparam int unsigned MAX_ELEMENTS = 16;
    localparam int unsigned ELEM_W       = 32;
    localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int unsigned COUNT_W      = $clog2(MAX_ELEMENTS + 1);

    // Set descriptor queue between the front and back parts (power of two depth).
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QLEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    // Result kind codes.
    typedef enum logic [2:0] {
        KIND_STORED    = 3'd0,
        KIND_REVERSED  = 3'd1,
        KIND_MAXIMUM   = 3'd2,
        KIND_MINIMUM   = 3'd3,
        KIND_DUPLICATE = 3'd4
    } t_kind;

    // Element store write request from the front part.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ELEM_W-1:0] data;
    } t_ram_wr;

    // One closed set: number of stored elements and its overflow mark.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_set_desc;

    typedef struct packed {
        logic      push;
        t_set_desc desc;
    } t_queue_push;

    typedef struct packed {
        logic      valid;
        t_set_desc desc;
    } t_queue_head;

    // Back part sequencer states.
    typedef enum logic [11:0] {
        ST_IDLE   = 12'h001,
        ST_FWD_RD = 12'h002,
        ST_FWD_EV = 12'h004,
        ST_REV_RD = 12'h008,
        ST_REV_EV = 12'h010,
        ST_MAX    = 12'h020,
        ST_MIN    = 12'h040,
        ST_DA_RD  = 12'h080,
        ST_DA_EV  = 12'h100,
        ST_DB_RD  = 12'h200,
        ST_DB_EV  = 12'h400,
        ST_FLUSH  = 12'h800
    } t_back_state;

endpackage

// ===== hw/rtl/aedu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module aedu_ram #(
    parameter int unsigned DATA_W = 32,
    parameter int unsigned DEPTH  = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]                         i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]                         o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/aedu_front.sv =====
// Front part: accepts elements, writes them to the store, closes sets.
// Depends on aedu_pkg.
module aedu_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [aedu_pkg::ELEM_W-1:0] i_element,
    input  logic                               i_end_of_set,
    input  logic                               i_set_done,
    output aedu_pkg::t_ram_wr                  o_ram_wr,
    output aedu_pkg::t_queue_push              o_queue_push
);

    logic [aedu_pkg::COUNT_W-1:0] r_count;
    logic [aedu_pkg::COUNT_W-1:0] n_count;
    logic                         r_ovf;
    logic                         n_ovf;
    logic                         r_pending;
    logic                         n_pending;
    logic                         accept;
    logic                         has_room;

    // A closed set owns the store until the back part has read it all.
    assign o_stall  = r_pending;
    assign accept   = i_valid && !r_pending;
    assign has_room = r_count < aedu_pkg::COUNT_W'(aedu_pkg::MAX_ELEMENTS);

    // Store the element or mark the overflow; close the set on its last transaction.
    always_comb begin
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_pending    = r_pending;
        o_ram_wr     = '0;
        o_queue_push = '0;
        if (accept) begin
            if (has_room) begin
                o_ram_wr.en   = 1'b1;
                o_ram_wr.addr = r_count[aedu_pkg::ADDR_W-1:0];
                o_ram_wr.data = i_element;
                n_count       = r_count + aedu_pkg::COUNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
            if (i_end_of_set) begin
                o_queue_push.push           = 1'b1;
                o_queue_push.desc.count     = n_count;
                o_queue_push.desc.overflow  = n_ovf;
                n_count   = '0;
                n_ovf     = 1'b0;
                n_pending = 1'b1;
            end
        end
        if (i_set_done) begin
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_pending <= n_pending;
        end
    end

endmodule

// ===== hw/rtl/aedu_queue.sv =====
// Short queue of closed set descriptors between the front and back parts.
// Depends on aedu_pkg.
module aedu_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aedu_pkg::t_queue_push i_push,
    input  logic                  i_pop,
    output aedu_pkg::t_queue_head o_head
);

    aedu_pkg::t_set_desc           r_entry [aedu_pkg::QUEUE_DEPTH];
    logic [aedu_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [aedu_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [aedu_pkg::QLEVEL_W-1:0] r_level;
    logic [aedu_pkg::QLEVEL_W-1:0] n_level;

    assign o_head.valid = (r_level != '0);
    assign o_head.desc  = r_entry[r_rd_ptr];

    // Fill level follows pushes and pops.
    always_comb begin
        case ({i_push.push, i_pop})
            2'b10:   n_level = r_level + aedu_pkg::QLEVEL_W'(1);
            2'b01:   n_level = r_level - aedu_pkg::QLEVEL_W'(1);
            default: n_level = r_level;
        endcase
    end

    // Descriptor storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_entry[r_wr_ptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + aedu_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + aedu_pkg::QPTR_W'(1);
            end
            r_level <= n_level;
        end
    end

endmodule

// ===== hw/rtl/aedu_back.sv =====
// Back part: walks a closed set in the store and produces its results.
// Depends on aedu_pkg; reads the store through the RAM's registered port.
module aedu_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aedu_pkg::t_queue_head               i_head,
    output logic                                o_pop,
    output logic                                o_rd_en,
    output logic [aedu_pkg::ADDR_W-1:0]         o_rd_addr,
    input  logic [aedu_pkg::ELEM_W-1:0]         i_rd_data,
    output logic                                o_set_done,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_kind,
    output logic signed [aedu_pkg::ELEM_W-1:0]  o_value,
    output logic                                o_final_result,
    output logic                                o_overflowed
);

    aedu_pkg::t_back_state        r_state;
    aedu_pkg::t_back_state        n_state;
    logic [aedu_pkg::COUNT_W-1:0] r_n;
    logic [aedu_pkg::COUNT_W-1:0] n_n;
    logic                         r_ovf;
    logic                         n_ovf;
    logic [aedu_pkg::COUNT_W-1:0] r_k;
    logic [aedu_pkg::COUNT_W-1:0] n_k;
    logic [aedu_pkg::COUNT_W-1:0] r_m;
    logic [aedu_pkg::COUNT_W-1:0] n_m;
    logic [aedu_pkg::ELEM_W-1:0]  r_a;
    logic [aedu_pkg::ELEM_W-1:0]  n_a;
    logic signed [aedu_pkg::ELEM_W-1:0] r_max;
    logic signed [aedu_pkg::ELEM_W-1:0] n_max;
    logic signed [aedu_pkg::ELEM_W-1:0] r_min;
    logic signed [aedu_pkg::ELEM_W-1:0] n_min;

    // One-result holding stage, so the last result can be marked final.
    logic                         r_hold_vld;
    logic                         n_hold_vld;
    aedu_pkg::t_kind              r_hold_kind;
    aedu_pkg::t_kind              n_hold_kind;
    logic [aedu_pkg::ELEM_W-1:0]  r_hold_value;
    logic [aedu_pkg::ELEM_W-1:0]  n_hold_value;

    // Output register.
    logic                         r_out_vld;
    logic                         n_out_vld;
    aedu_pkg::t_kind              r_out_kind;
    aedu_pkg::t_kind              n_out_kind;
    logic [aedu_pkg::ELEM_W-1:0]  r_out_value;
    logic [aedu_pkg::ELEM_W-1:0]  n_out_value;
    logic                         r_out_final;
    logic                         n_out_final;
    logic                         r_out_ovf;
    logic                         n_out_ovf;

    logic                         out_free;
    logic                         can_push;
    logic                         push;
    aedu_pkg::t_kind              push_kind;
    logic [aedu_pkg::ELEM_W-1:0]  push_value;
    logic                         flush_move;
    logic [aedu_pkg::COUNT_W-1:0] last_idx;
    logic signed [aedu_pkg::ELEM_W-1:0] rd_val;

    assign out_free = !r_out_vld || !i_stall;
    assign can_push = !r_hold_vld || out_free;
    assign last_idx = r_n - aedu_pkg::COUNT_W'(1);
    assign rd_val   = $signed(i_rd_data);

    // Sequencer: stored order with min/max tracking, reversed order,
    // extremes, then the pairwise duplicate scan.
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_ovf      = r_ovf;
        n_k        = r_k;
        n_m        = r_m;
        n_a        = r_a;
        n_max      = r_max;
        n_min      = r_min;
        push       = 1'b0;
        push_kind  = aedu_pkg::KIND_STORED;
        push_value = '0;
        flush_move = 1'b0;
        o_pop      = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_k[aedu_pkg::ADDR_W-1:0];
        o_set_done = 1'b0;
        case (r_state)
            aedu_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_n     = i_head.desc.count;
                    n_ovf   = i_head.desc.overflow;
                    n_k     = '0;
                    n_state = aedu_pkg::ST_FWD_RD;
                end
            end
            aedu_pkg::ST_FWD_RD: begin
                o_rd_en = 1'b1;
                n_state = aedu_pkg::ST_FWD_EV;
            end
            aedu_pkg::ST_FWD_EV: begin
                if (can_push) begin
                    push       = 1'b1;
                    push_kind  = aedu_pkg::KIND_STORED;
                    push_value = i_rd_data;
                    if ((r_k == '0) || (rd_val > r_max)) begin
                        n_max = rd_val;
                    end
                    if ((r_k == '0) || (rd_val < r_min)) begin
                        n_min = rd_val;
                    end
                    if (r_k == last_idx) begin
                        n_state = aedu_pkg::ST_REV_RD;
                    end else begin
                        n_k     = r_k + aedu_pkg::COUNT_W'(1);
                        n_state = aedu_pkg::ST_FWD_RD;
                    end
                end
            end
            aedu_pkg::ST_REV_RD: begin
                o_rd_en = 1'b1;
                n_state = aedu_pkg::ST_REV_EV;
            end
            aedu_pkg::ST_REV_EV: begin
                if (can_push) begin
                    push       = 1'b1;
                    push_kind  = aedu_pkg::KIND_REVERSED;
                    push_value = i_rd_data;
                    if (r_k == '0) begin
                        n_state = aedu_pkg::ST_MAX;
                    end else begin
                        n_k     = r_k - aedu_pkg::COUNT_W'(1);
                        n_state = aedu_pkg::ST_REV_RD;
                    end
                end
            end
            aedu_pkg::ST_MAX: begin
                if (can_push) begin
                    push       = 1'b1;
                    push_kind  = aedu_pkg::KIND_MAXIMUM;
                    push_value = r_max;
                    n_state    = aedu_pkg::ST_MIN;
                end
            end
            aedu_pkg::ST_MIN: begin
                if (can_push) begin
                    push       = 1'b1;
                    push_kind  = aedu_pkg::KIND_MINIMUM;
                    push_value = r_min;
                    n_k        = '0;
                    n_state    = aedu_pkg::ST_DA_RD;
                end
            end
            aedu_pkg::ST_DA_RD: begin
                // The last position has no later partner: the scan is over and
                // the store is released to the front part.
                if (r_k == last_idx) begin
                    o_set_done = 1'b1;
                    n_state    = aedu_pkg::ST_FLUSH;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = aedu_pkg::ST_DA_EV;
                end
            end
            aedu_pkg::ST_DA_EV: begin
                n_a     = i_rd_data;
                n_m     = r_k + aedu_pkg::COUNT_W'(1);
                n_state = aedu_pkg::ST_DB_RD;
            end
            aedu_pkg::ST_DB_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_m[aedu_pkg::ADDR_W-1:0];
                n_state   = aedu_pkg::ST_DB_EV;
            end
            aedu_pkg::ST_DB_EV: begin
                // A match reports position k once and moves on to the next k.
                if (i_rd_data == r_a) begin
                    if (can_push) begin
                        push       = 1'b1;
                        push_kind  = aedu_pkg::KIND_DUPLICATE;
                        push_value = r_a;
                        n_k        = r_k + aedu_pkg::COUNT_W'(1);
                        n_state    = aedu_pkg::ST_DA_RD;
                    end
                end else if (r_m == last_idx) begin
                    n_k     = r_k + aedu_pkg::COUNT_W'(1);
                    n_state = aedu_pkg::ST_DA_RD;
                end else begin
                    n_m     = r_m + aedu_pkg::COUNT_W'(1);
                    n_state = aedu_pkg::ST_DB_RD;
                end
            end
            aedu_pkg::ST_FLUSH: begin
                if (out_free) begin
                    flush_move = 1'b1;
                    n_state    = aedu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aedu_pkg::ST_IDLE;
            end
        endcase
    end

    // Holding stage and output register movement.
    always_comb begin
        n_hold_vld   = r_hold_vld;
        n_hold_kind  = r_hold_kind;
        n_hold_value = r_hold_value;
        n_out_vld    = r_out_vld && i_stall;
        n_out_kind   = r_out_kind;
        n_out_value  = r_out_value;
        n_out_final  = r_out_final;
        n_out_ovf    = r_out_ovf;
        if (push) begin
            if (r_hold_vld) begin
                n_out_vld   = 1'b1;
                n_out_kind  = r_hold_kind;
                n_out_value = r_hold_value;
                n_out_final = 1'b0;
                n_out_ovf   = r_ovf;
            end
            n_hold_vld   = 1'b1;
            n_hold_kind  = push_kind;
            n_hold_value = push_value;
        end
        if (flush_move) begin
            n_out_vld   = 1'b1;
            n_out_kind  = r_hold_kind;
            n_out_value = r_hold_value;
            n_out_final = 1'b1;
            n_out_ovf   = r_ovf;
            n_hold_vld  = 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_ovf        <= n_ovf;
        r_k          <= n_k;
        r_m          <= n_m;
        r_a          <= n_a;
        r_max        <= n_max;
        r_min        <= n_min;
        r_hold_kind  <= n_hold_kind;
        r_hold_value <= n_hold_value;
        r_out_kind   <= n_out_kind;
        r_out_value  <= n_out_value;
        r_out_final  <= n_out_final;
        r_out_ovf    <= n_out_ovf;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= aedu_pkg::ST_IDLE;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_kind         = r_out_kind;
    assign o_value        = $signed(r_out_value);
    assign o_final_result = r_out_final;
    assign o_overflowed   = r_out_ovf;

endmodule

// ===== hw/rtl/array_extremes_and_duplicates_unit.sv =====
// Loading: one element per cycle while o_stall is low; the last element of a set raises o_stall,
// which stays high until the duplicate scan of that set ends; the store has a single read port
// (a read state and an evaluate state per visited element). Each result passes through a
// holding stage and then the output register, so the last one can be marked final. Synchronous
// active-low reset clears all control state; store contents are not cleared.
module array_extremes_and_duplicates_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [aedu_pkg::ELEM_W-1:0] i_element,
    input  logic                               i_end_of_set,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [2:0]                         o_kind,
    output logic signed [aedu_pkg::ELEM_W-1:0] o_value,
    output logic                               o_final_result,
    output logic                               o_overflowed
);

    aedu_pkg::t_ram_wr             ram_wr;
    aedu_pkg::t_queue_push         queue_push;
    aedu_pkg::t_queue_head         queue_head;
    logic                          queue_pop;
    logic                          set_done;
    logic                          rd_en;
    logic [aedu_pkg::ADDR_W-1:0]   rd_addr;
    logic [aedu_pkg::ELEM_W-1:0]   rd_data;

    // Front part: element intake.
    aedu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_element    (i_element),
        .i_end_of_set (i_end_of_set),
        .i_set_done   (set_done),
        .o_ram_wr     (ram_wr),
        .o_queue_push (queue_push)
    );

    // Element store.
    aedu_ram #(
        .DATA_W (aedu_pkg::ELEM_W),
        .DEPTH  (aedu_pkg::MAX_ELEMENTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr.en),
        .i_wr_addr (ram_wr.addr),
        .i_wr_data (ram_wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Closed set queue.
    aedu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_pop   (queue_pop),
        .o_head  (queue_head)
    );

    // Back part: result generation.
    aedu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (queue_head),
        .o_pop          (queue_pop),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_set_done     (set_done),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_value        (o_value),
        .o_final_result (o_final_result),
        .o_overflowed   (o_overflowed)
    );

endmodule

// ===== hw/rtl/aedu_checker.sv =====
// Port-level checker for the array extremes and duplicates unit, bound to the top level.
// Depends on aedu_pkg and array_extremes_and_duplicates_unit_assert.svh.
`include "array_extremes_and_duplicates_unit_assert.svh"

module aedu_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic signed [aedu_pkg::ELEM_W-1:0] i_element,
    input logic                               i_end_of_set,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [2:0]                         o_kind,
    input logic signed [aedu_pkg::ELEM_W-1:0] o_value,
    input logic                               o_final_result,
    input logic                               o_overflowed
);

    logic r_expect_first;

    // Tracks whether the next result transaction opens a new set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_first <= 1'b1;
        end else if (o_valid && !i_stall) begin
            r_expect_first <= o_final_result;
        end
    end

    // A stalled result keeps its payload.
    `AEDU_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_value) && $stable(o_kind) && $stable(o_final_result) && $stable(o_overflowed))

    // Every set opens with its first element in stored order.
    `AEDU_ASSERT_IMPL(a_set_opens_stored, o_valid && r_expect_first, o_kind == aedu_pkg::KIND_STORED)

    // Intake stalls only after a transaction that closed a set.
    `AEDU_ASSERT_IMPL(a_stall_after_last, $rose(o_stall), $past(i_valid && i_end_of_set))

    // The closing result is the minimum or a duplicate.
    `AEDU_ASSERT_IMPL(a_final_kind, o_valid && o_final_result, o_kind == aedu_pkg::KIND_MINIMUM || o_kind == aedu_pkg::KIND_DUPLICATE)

endmodule

bind array_extremes_and_duplicates_unit aedu_checker u_checker (.*);
